[hdl/pcqs_pkg.sv]
// shared types and constants for the priority command queue scheduler
// no dependencies
package pcqs_pkg;

    localparam int QueueDepth     = 10;
    localparam int PriorityLevels = 4;
    localparam int SlotW          = $clog2(QueueDepth);
    localparam int CountW         = $clog2(QueueDepth + 1);
    localparam int PrioW          = 2;
    localparam int EntryW         = PrioW + 8 + 32 + 16 + 32;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [0:0] CFG_IDLE_MODE  = 1'd0;
    localparam logic [0:0] CFG_IDLE_COLOR = 1'd1;

    typedef struct packed {
        logic [PrioW-1:0] prio;
        logic [7:0]       mode;
        logic [31:0]      color;
        logic [15:0]      speed;
        logic [31:0]      dur;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_RD,
        ST_SUB_CHK,
        ST_TICK_RD,
        ST_TICK_EVAL,
        ST_TICK_DONE
    } t_state;

    // ring slot step with wrap
    function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
        logic [SlotW-1:0] r;
        if (s == SlotW'(QueueDepth - 1)) r = '0;
        else r = s + SlotW'(1);
        return r;
    endfunction

    // head plus count, both below depth (count may equal depth)
    function automatic logic [SlotW-1:0] slot_add(input logic [SlotW-1:0] h,
                                                  input logic [CountW-1:0] c);
        logic [CountW:0] s;
        s = (CountW+1)'(h) + (CountW+1)'(c);
        if (s >= (CountW+1)'(QueueDepth)) s = s - (CountW+1)'(QueueDepth);
        return s[SlotW-1:0];
    endfunction

endpackage

[hdl/pcqs_ram.sv]
// ring entry store, one write port and one registered read port
// depends on pcqs_pkg
module pcqs_ram import pcqs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [SlotW-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [SlotW-1:0] i_raddr,
    output t_entry           o_rdata
);
    t_entry r_mem [QueueDepth];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/priority_command_queue_scheduler.sv]
// top level of the priority command queue scheduler: sequencer around the ring store
// depends on pcqs_pkg and pcqs_ram
//
//  channel   handshake              payload
//  command   i_start / o_busy       i_operation .. i_now_ms
//  result    o_valid (strobe)       o_accepted .. o_out_speed
//  config    i_cfg_we               i_cfg_index, i_cfg_data
//
// clear and unused codes answer straight from idle; submit reads the oldest slot, then checks it
// tick pops and requeues the ring entries one at a time, in a read state and an evaluate state,
// through the single store read port
// synchronous active-low reset; the ring store needs no clearing
// result is a one-cycle strobe, the receiver cannot stall
module priority_command_queue_scheduler import pcqs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_priority_req,
    input  logic [7:0]  i_mode,
    input  logic [31:0] i_color,
    input  logic [15:0] i_speed,
    input  logic [31:0] i_duration_ms,
    input  logic [47:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic        o_accepted,
    output logic        o_applied,
    output logic [7:0]  o_out_mode,
    output logic [31:0] o_out_color,
    output logic        o_speed_write,
    output logic [15:0] o_out_speed
);
    t_state r_state, n_state;

    // control registers
    logic [SlotW-1:0]  r_head, n_head;
    logic [CountW-1:0] r_count, n_count;
    logic [PrioW-1:0]  r_act_prio, n_act_prio;
    logic [31:0]       r_act_dur, n_act_dur;
    logic [47:0]       r_act_start, n_act_start;
    logic [7:0]        r_idle_mode;
    logic [31:0]       r_idle_color;

    // current command word and tick working state
    t_entry            r_cmd, n_cmd;
    logic [1:0]        r_op, n_op;
    logic [47:0]       r_now, n_now;
    logic [CountW-1:0] r_left, n_left;
    logic              r_found, n_found;
    t_entry            r_best, n_best;

    // result word
    logic        r_valid, n_valid;
    logic        r_acc, n_acc;
    logic        r_app, n_app;
    logic [7:0]  r_omode, n_omode;
    logic [31:0] r_ocolor, n_ocolor;
    logic        r_sw, n_sw;
    logic [15:0] r_ospeed, n_ospeed;

    // ring store port
    logic             w_we;
    logic [SlotW-1:0] w_waddr, w_raddr;
    t_entry           w_wdata, w_rdata;

    logic [PrioW-1:0] w_sat_prio;
    logic [48:0]      w_elapsed;

    pcqs_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // saturation is a no-op at four levels but kept with the level count
    assign w_sat_prio = (32'(i_priority_req) > 32'(PriorityLevels - 1))
                        ? PrioW'(PriorityLevels - 1) : i_priority_req;
    assign w_elapsed  = {1'b0, i_now_ms} - {1'b0, r_act_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_act_prio   <= '0;
            r_act_dur    <= '0;
            r_act_start  <= '0;
            r_idle_mode  <= 8'd0;
            r_idle_color <= 32'h00FF_FF00;
            r_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_act_prio  <= n_act_prio;
            r_act_dur   <= n_act_dur;
            r_act_start <= n_act_start;
            r_valid     <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IDLE_MODE:  r_idle_mode  <= i_cfg_data[7:0];
                    CFG_IDLE_COLOR: r_idle_color <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_op     <= n_op;
        r_now    <= n_now;
        r_left   <= n_left;
        r_found  <= n_found;
        r_best   <= n_best;
        r_acc    <= n_acc;
        r_app    <= n_app;
        r_omode  <= n_omode;
        r_ocolor <= n_ocolor;
        r_sw     <= n_sw;
        r_ospeed <= n_ospeed;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_operation == OP_SUBMIT) n_state = ST_SUB_RD;
                    else if (i_operation == OP_TICK) n_state = ST_TICK_RD;
                end
            end
            ST_SUB_RD:    n_state = ST_SUB_CHK;
            ST_SUB_CHK:   n_state = ST_IDLE;
            ST_TICK_RD:   n_state = (r_left == '0) ? ST_TICK_DONE : ST_TICK_EVAL;
            ST_TICK_EVAL: n_state = ST_TICK_RD;
            ST_TICK_DONE: n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_act_prio  = r_act_prio;
        n_act_dur   = r_act_dur;
        n_act_start = r_act_start;
        n_cmd       = r_cmd;
        n_op        = r_op;
        n_now       = r_now;
        n_left      = r_left;
        n_found     = r_found;
        n_best      = r_best;
        n_valid     = 1'b0;
        n_acc       = 1'b0;
        n_app       = 1'b0;
        n_omode     = '0;
        n_ocolor    = '0;
        n_sw        = 1'b0;
        n_ospeed    = '0;
        w_we        = 1'b0;
        w_waddr     = slot_add(r_head, r_count);
        w_wdata     = r_cmd;
        w_raddr     = r_head;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_op        = i_operation;
                    n_now       = i_now_ms;
                    n_cmd.prio  = w_sat_prio;
                    n_cmd.mode  = i_mode;
                    n_cmd.color = i_color;
                    n_cmd.speed = i_speed;
                    n_cmd.dur   = i_duration_ms;
                    n_found     = 1'b0;
                    n_left      = r_count;
                    case (i_operation)
                        OP_TICK: begin
                            // expiry of a timed active command
                            if (r_act_dur != '0 && !w_elapsed[48] &&
                                w_elapsed[47:0] >= {16'd0, r_act_dur}) begin
                                n_act_prio = '0;
                                n_act_dur  = '0;
                            end
                        end
                        OP_CLEAR: begin
                            n_head     = '0;
                            n_count    = '0;
                            n_act_prio = '0;
                            n_act_dur  = '0;
                            n_valid    = 1'b1;
                            n_app      = 1'b1;
                            n_omode    = r_idle_mode;
                            n_ocolor   = r_idle_color;
                        end
                        OP_SUBMIT: ;
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            ST_SUB_RD: ;
            ST_SUB_CHK: begin
                n_valid = 1'b1;
                if (r_cmd.prio >= r_act_prio) begin
                    if (32'(r_count) < 32'(QueueDepth)) begin
                        w_we    = 1'b1;
                        n_count = r_count + CountW'(1);
                        n_acc   = 1'b1;
                    end else if (r_cmd.prio > w_rdata.prio) begin
                        // full: oldest slot is the tail slot, overwrite and advance
                        w_we    = 1'b1;
                        w_waddr = r_head;
                        n_head  = slot_inc(r_head);
                        n_acc   = 1'b1;
                    end
                end
            end
            ST_TICK_RD: ;
            ST_TICK_EVAL: begin
                // popped entry is w_rdata; a requeued entry goes to the tail slot
                n_head  = slot_inc(r_head);
                n_left  = r_left - CountW'(1);
                w_waddr = r_head;
                if (w_rdata.prio > r_act_prio) begin
                    if (!r_found || w_rdata.prio > r_best.prio) begin
                        if (r_found) begin
                            w_we    = 1'b1;
                            w_wdata = r_best;
                        end else begin
                            n_count = r_count - CountW'(1);
                        end
                        n_best  = w_rdata;
                        n_found = 1'b1;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata;
                    end
                end else if (w_rdata.prio == r_act_prio && !r_found) begin
                    n_best  = w_rdata;
                    n_found = 1'b1;
                    n_count = r_count - CountW'(1);
                end else begin
                    w_we    = 1'b1;
                    w_wdata = w_rdata;
                end
                // entries kept go to the tail, which lines up with the head slot
                // being vacated only while the ring is full
                if (w_we && r_found) w_waddr = slot_add(r_head, r_count);
                if (w_we && !r_found) w_waddr = slot_add(r_head, r_count);
            end
            ST_TICK_DONE: begin
                n_valid = 1'b1;
                if (r_found) begin
                    n_act_prio  = r_best.prio;
                    n_act_dur   = r_best.dur;
                    n_act_start = r_now;
                    n_app       = 1'b1;
                    n_omode     = r_best.mode;
                    n_ocolor    = r_best.color;
                    if (r_best.speed != '0) begin
                        n_sw     = 1'b1;
                        n_ospeed = r_best.speed;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_busy        = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_accepted    = r_acc;
    assign o_applied     = r_app;
    assign o_out_mode    = r_omode;
    assign o_out_color   = r_ocolor;
    assign o_speed_write = r_sw;
    assign o_out_speed   = r_ospeed;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(QueueDepth))
        else $error("ring count above depth");
    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_head) < 32'(QueueDepth))
        else $error("ring head out of range");
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_DONE) |=> o_valid)
        else $error("tick finished without result");
    a_accept_submit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_accepted) |-> (r_op == OP_SUBMIT))
        else $error("accepted on non-submit");
`endif
endmodule

[tb/pcqs_checker.sv]
// result checker for the priority command queue scheduler: predicts each result word
// from the accepted command words and compares it as one word, showing each field on a mismatch
// depends on pcqs_pkg
module pcqs_checker import pcqs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_priority_req,
    input  logic [7:0]  i_mode,
    input  logic [31:0] i_color,
    input  logic [15:0] i_speed,
    input  logic [31:0] i_duration_ms,
    input  logic [47:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_accepted,
    input  logic        i_applied,
    input  logic [7:0]  i_out_mode,
    input  logic [31:0] i_out_color,
    input  logic        i_speed_write,
    input  logic [15:0] i_out_speed,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        accepted;
        logic        applied;
        logic [7:0]  mode;
        logic [31:0] color;
        logic        speed_write;
        logic [15:0] speed;
    } t_result;

    t_result     expected_q[$];
    t_entry      ring[QueueDepth];
    int          head, count;
    logic [1:0]  act_prio;
    logic [31:0] act_dur;
    logic [47:0] act_start;
    logic [7:0]  idle_mode;
    logic [31:0] idle_color;

    assign o_pending = expected_q.size();

    function automatic void ring_push(t_entry e);
        if (count < QueueDepth) begin
            ring[(head + count) % QueueDepth] = e;
            count++;
        end
    endfunction

    function automatic t_entry ring_pop();
        t_entry e;
        e = ring[head];
        head = (head + 1) % QueueDepth;
        count--;
        return e;
    endfunction

    // behaviour of one command word, updates the shadow state
    function automatic t_result schedule_word(logic [1:0] op, t_entry cmd, logic [47:0] now);
        t_result r;
        t_entry  best, e;
        bit      found;
        int      n;
        r = '0;
        found = 0;
        best = '0;
        case (op)
            OP_SUBMIT: begin
                if (cmd.prio >= act_prio) begin
                    if (count < QueueDepth) begin
                        ring_push(cmd);
                        r.accepted = 1;
                    end else if (cmd.prio > ring[head].prio) begin
                        e = ring_pop();
                        ring_push(cmd);
                        r.accepted = 1;
                    end
                end
            end
            OP_TICK: begin
                // timed active command runs out, time going backwards never expires it
                if (act_dur != 0 && now >= act_start &&
                    (now - act_start) >= {16'd0, act_dur}) begin
                    act_prio = '0;
                    act_dur = '0;
                end
                n = count;
                for (int i = 0; i < n; i++) begin
                    e = ring_pop();
                    if (e.prio > act_prio) begin
                        if (!found || e.prio > best.prio) begin
                            if (found) ring_push(best);
                            best = e;
                            found = 1;
                        end else begin
                            ring_push(e);
                        end
                    end else if (e.prio == act_prio && !found) begin
                        best = e;
                        found = 1;
                    end else begin
                        ring_push(e);
                    end
                end
                if (found) begin
                    act_prio = best.prio;
                    act_dur = best.dur;
                    act_start = now;
                    r.applied = 1;
                    r.mode = best.mode;
                    r.color = best.color;
                    if (best.speed != 0) begin
                        r.speed_write = 1;
                        r.speed = best.speed;
                    end
                end
            end
            OP_CLEAR: begin
                head = 0;
                count = 0;
                act_prio = '0;
                act_dur = '0;
                r.applied = 1;
                r.mode = idle_mode;
                r.color = idle_color;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, exp_r;
        t_entry  cmd;
        if (!i_rst_n) begin
            expected_q.delete();
            head = 0;
            count = 0;
            act_prio = '0;
            act_dur = '0;
            act_start = '0;
            idle_mode = 8'd0;
            idle_color = 32'hFFFF00;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDLE_MODE) idle_mode = i_cfg_data[7:0];
                else idle_color = i_cfg_data;
            end
            if (i_valid) begin
                got = '{i_accepted, i_applied, i_out_mode, i_out_color,
                        i_speed_write, i_out_speed};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        if (o_fail_count < 10)
                            $display("mismatch: exp acc %b app %b mode %h col %h sw %b spd %h, got acc %b app %b mode %h col %h sw %b spd %h",
                                exp_r.accepted, exp_r.applied, exp_r.mode, exp_r.color,
                                exp_r.speed_write, exp_r.speed, got.accepted, got.applied,
                                got.mode, got.color, got.speed_write, got.speed);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                cmd = '{i_priority_req, i_mode, i_color, i_speed, i_duration_ms};
                expected_q.push_back(schedule_word(i_operation, cmd, i_now_ms));
            end
        end
    end

endmodule

[tb/tb.sv]
// testbench top for the priority command queue scheduler: command stimulus,
// idle register writes, watchdog and verdict; depends on pcqs_pkg, pcqs_checker and the block
module tb;
    import pcqs_pkg::*;

    logic        i_clk = 0, i_rst_n = 0, i_start = 0, i_cfg_we = 0;
    logic [1:0]  i_operation = '0, i_priority_req = '0;
    logic [7:0]  i_mode = '0;
    logic [31:0] i_color = '0, i_duration_ms = '0, i_cfg_data = '0;
    logic [15:0] i_speed = '0;
    logic [47:0] i_now_ms = '0;
    logic [0:0]  i_cfg_index = '0;
    logic        o_busy, o_valid, o_accepted, o_applied, o_speed_write;
    logic [7:0]  o_out_mode;
    logic [31:0] o_out_color;
    logic [15:0] o_out_speed;
    int          fail_count, pending, idle_cycles;
    logic [47:0] clock_ms;   // running time for ticks

    initial forever #4 i_clk = ~i_clk;

    priority_command_queue_scheduler uut (.*);

    pcqs_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_operation, .i_priority_req,
        .i_mode, .i_color, .i_speed, .i_duration_ms, .i_now_ms, .i_cfg_we,
        .i_cfg_index, .i_cfg_data, .i_valid(o_valid), .i_accepted(o_accepted),
        .i_applied(o_applied), .i_out_mode(o_out_mode), .i_out_color(o_out_color),
        .i_speed_write(o_speed_write), .i_out_speed(o_out_speed),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // present one command word and hold it until taken; start stays high afterwards
    task automatic send_word(logic [1:0] op, logic [1:0] prio, logic [7:0] mode,
                             logic [31:0] color, logic [15:0] speed,
                             logic [31:0] dur, logic [47:0] now);
        i_start <= 1;
        i_operation <= op;
        i_priority_req <= prio;
        i_mode <= mode;
        i_color <= color;
        i_speed <= speed;
        i_duration_ms <= dur;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic pause_sender(int cycles);
        i_start <= 0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // register writes only once the block has drained
    task automatic write_idle(logic [0:0] idx, logic [31:0] data);
        i_start <= 0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_word();
        int          pick;
        logic [1:0]  op;
        logic [31:0] dur;
        logic [47:0] now;
        pick = $urandom_range(0, 99);
        // mostly submits and ticks, some clears and the unused code
        if (pick < 55) op = OP_SUBMIT;
        else if (pick < 90) op = OP_TICK;
        else if (pick < 96) op = OP_CLEAR;
        else op = OP_UNUSED;
        dur = ($urandom_range(0, 9) == 0) ? $urandom :
              (($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 600));
        if (op == OP_TICK) begin
            pick = $urandom_range(0, 49);
            if (pick == 0) clock_ms = 48'({$urandom, $urandom});
            else if (pick == 1) clock_ms = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 500);
            else clock_ms = clock_ms + $urandom_range(0, 300);
            now = clock_ms;
        end else begin
            now = 48'({$urandom, $urandom});
        end
        send_word(op, 2'($urandom_range(0, 3)), 8'($urandom), $urandom, 16'($urandom),
                  dur, now);
    endtask

    initial begin
        clock_ms = 48'd1000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed part: clear at reset idle values, then extremes
        send_word(OP_CLEAR, 2'd0, 8'd0, 32'd0, 16'd0, 32'd0, 48'd0);
        write_idle(CFG_IDLE_MODE, 32'hFF);
        write_idle(CFG_IDLE_COLOR, 32'hFFFF_FFFF);
        send_word(OP_CLEAR, 2'd0, 8'd0, 32'd0, 16'd0, 32'd0, 48'd0);
        send_word(OP_UNUSED, 2'd3, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
                  48'hFFFF_FFFF_FFFF);
        // fill the ring past full: low priority refused, higher displaces oldest
        for (int k = 0; k < 11; k++)
            send_word(OP_SUBMIT, 2'(k % 3), 8'(k), 32'hA5A5_0000 + 32'(k),
                      k[0] ? 16'd0 : 16'hFFFF, k == 3 ? 32'd100 : 32'd0, 48'd0);
        send_word(OP_SUBMIT, 2'd0, 8'h11, 32'h1, 16'h1, 32'd0, 48'd0);
        send_word(OP_SUBMIT, 2'd3, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd50, 48'd0);
        send_word(OP_TICK, 2'd0, 8'd0, 32'd0, 16'd0, 32'd0, 48'd1000);
        // lower priority submit against an active priority 3 is refused
        send_word(OP_SUBMIT, 2'd1, 8'h22, 32'h2, 16'h2, 32'd0, 48'd0);
        // time going backwards does not expire, then expiry at exactly the duration
        send_word(OP_TICK, 2'd0, 8'd0, 32'd0, 16'd0, 32'd0, 48'd10);
        send_word(OP_TICK, 2'd0, 8'd0, 32'd0, 16'd0, 32'd0, 48'd1050);
        send_word(OP_TICK, 2'd0, 8'd0, 32'd0, 16'd0, 32'd0, 48'd1051);
        pause_sender(3);
        write_idle(CFG_IDLE_MODE, 32'h00);
        write_idle(CFG_IDLE_COLOR, 32'h0);
        send_word(OP_CLEAR, 2'd0, 8'd0, 32'd0, 16'd0, 32'd0, 48'd0);

        // random part in bursts, with a few mid-run register settings
        for (int b = 0; b < 500; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) random_word();
            b += burst;
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
            if ($urandom_range(0, 40) == 0) begin
                write_idle(CFG_IDLE_MODE, $urandom);
                write_idle(CFG_IDLE_COLOR, $urandom);
            end
        end
        i_start <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule

[priority_command_queue_scheduler.f]
hdl/pcqs_pkg.sv
hdl/pcqs_ram.sv
hdl/priority_command_queue_scheduler.sv
tb/pcqs_checker.sv
tb/tb.sv
